>>> sv/fan_speed_pi_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// Fan speed PI controller assertion macros
// Concurrent property shorthands clocked on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FAN_SPEED_PI_CONTROLLER_UNIT_ASSERT_SVH
`define FAN_SPEED_PI_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define FSPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fspc assertion failed");

// next-cycle implication
`define FSPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fspc assertion failed");

`endif

>>> sv/fspc_pkg.sv
// ----------------------------------------------------------------------------
// Fan speed PI controller package
// Command codes, register indexes, fixed constants, FSM state and interfaces.
// ----------------------------------------------------------------------------
package fspc_pkg;

    localparam int DIV_W = 34;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [1:0] CMD_PULSE  = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_TARGET = 2'd2;

    localparam logic [3:0] REG_GAIN_P       = 4'd0;
    localparam logic [3:0] REG_GAIN_I       = 4'd1;
    localparam logic [3:0] REG_DUTY_FLOOR   = 4'd2;
    localparam logic [3:0] REG_DUTY_CEILING = 4'd3;
    localparam logic [3:0] REG_TGT_FLOOR    = 4'd4;
    localparam logic [3:0] REG_TGT_CEILING  = 4'd5;
    localparam logic [3:0] REG_DEBOUNCE     = 4'd6;
    localparam logic [3:0] REG_STALL        = 4'd7;

    localparam logic [15:0] RST_GAIN_P       = 16'd1966;
    localparam logic [15:0] RST_GAIN_I       = 16'd328;
    localparam logic [7:0]  RST_DUTY_FLOOR   = 8'd10;
    localparam logic [7:0]  RST_DUTY_CEILING = 8'd245;
    localparam logic [12:0] RST_TGT_FLOOR    = 13'd1400;
    localparam logic [12:0] RST_TGT_CEILING  = 13'd4000;
    localparam logic [15:0] RST_DEBOUNCE     = 16'd3000;
    localparam logic [23:0] RST_STALL        = 24'd500000;
    localparam logic [23:0] RST_DUTY_ACC     = 24'h0A0000;
    localparam logic [12:0] RST_TARGET       = 13'd1400;

    localparam logic [DIV_W-1:0] SPEED_NUM   = 34'd15360000000;
    localparam logic [DIV_W-1:0] SPEED_LIMIT = 34'd1536000;
    // ceil(2^26 / 5): quotient by five for sums below 2^26
    localparam logic [23:0]      EMA_RECIP   = 24'd13421773;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_CHECK     = 13'b0000000000010,
        S_MEDIAN    = 13'b0000000000100,
        S_MED_DONE  = 13'b0000000001000,
        S_DIV_SPEED = 13'b0000000010000,
        S_RAW_CHECK = 13'b0000000100000,
        S_DIV_EMA   = 13'b0000001000000,
        S_EMA_WRITE = 13'b0000010000000,
        S_PI_P      = 13'b0000100000000,
        S_PI_I      = 13'b0001000000000,
        S_PI_SUM    = 13'b0010000000000,
        S_PI_ACC    = 13'b0100000000000,
        S_DONE      = 13'b1000000000000
    } t_state;

    typedef struct packed {
        logic accept;
        logic stall_set;
        logic med_clear;
        logic med_step;
        logic div_speed;
        logic div_ema;
        logic div_step;
        logic ema_write;
        logic mul_p;
        logic mul_i;
        logic pi_sum;
        logic pi_acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic age_over;
        logic med_last;
        logic med_zero;
        logic div_done;
        logic raw_ok;
        logic out_free;
    } t_sts;

endpackage

>>> sv/fspc_ctrl.sv
// ----------------------------------------------------------------------------
// Fan speed PI controller sequencer
// One-hot FSM that steps the datapath through stall check, median, divides
// and the PI update of one tick.
// ----------------------------------------------------------------------------
module fspc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_command,
    input  fspc_pkg::t_sts  i_sts,
    output logic            o_ready,
    output fspc_pkg::t_cmd  o_cmd
);
    import fspc_pkg::*;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_command == CMD_TICK) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.age_over) begin
                    o_cmd.stall_set = 1'b1;
                    n_state = S_PI_P;
                end else begin
                    o_cmd.med_clear = 1'b1;
                    n_state = S_MEDIAN;
                end
            end
            S_MEDIAN: begin
                o_cmd.med_step = 1'b1;
                if (i_sts.med_last) n_state = S_MED_DONE;
            end
            S_MED_DONE: begin
                if (i_sts.med_zero) begin
                    n_state = S_PI_P;
                end else begin
                    o_cmd.div_speed = 1'b1;
                    n_state = S_DIV_SPEED;
                end
            end
            S_DIV_SPEED: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_RAW_CHECK;
            end
            S_RAW_CHECK: begin
                if (i_sts.raw_ok) begin
                    n_state = S_DIV_EMA;
                end else begin
                    n_state = S_PI_P;
                end
            end
            S_DIV_EMA: begin
                o_cmd.div_ema = 1'b1;
                n_state = S_EMA_WRITE;
            end
            S_EMA_WRITE: begin
                o_cmd.ema_write = 1'b1;
                n_state = S_PI_P;
            end
            S_PI_P: begin
                o_cmd.mul_p = 1'b1;
                n_state = S_PI_I;
            end
            S_PI_I: begin
                o_cmd.mul_i = 1'b1;
                n_state = S_PI_SUM;
            end
            S_PI_SUM: begin
                o_cmd.pi_sum = 1'b1;
                n_state = S_PI_ACC;
            end
            S_PI_ACC: begin
                o_cmd.pi_acc = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/fspc_dp.sv
// ----------------------------------------------------------------------------
// Fan speed PI controller datapath
// Config registers, period ring, median search, serial speed divider,
// reciprocal filter multiply, shared PI multiplier, accumulator and output.
// ----------------------------------------------------------------------------
module fspc_dp #(
    parameter int RING_DEPTH     = 5,
    parameter int PULSES_PER_REV = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fspc_pkg::t_cmd  i_cmd,
    output fspc_pkg::t_sts  o_sts,
    input  logic [1:0]      i_command,
    input  logic [31:0]     i_time_us,
    input  logic [15:0]     i_target_rpm,
    input  logic            i_cfg_valid,
    input  logic [3:0]      i_cfg_index,
    input  logic [23:0]     i_cfg_data,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [7:0]      o_duty_level,
    output logic [12:0]     o_speed_rpm,
    output logic            o_stalled
);
    import fspc_pkg::*;

    localparam int IW    = $clog2(RING_DEPTH);
    localparam int CW    = $clog2(RING_DEPTH + 1);
    localparam int MED_K = RING_DEPTH / 2;

    logic [15:0] r_gain_p, r_gain_i, r_debounce;
    logic [7:0]  r_duty_floor, r_duty_ceiling;
    logic [12:0] r_tgt_floor, r_tgt_ceiling;
    logic [23:0] r_stall_to;

    logic [31:0] r_ring [RING_DEPTH];
    logic [IW-1:0] r_pos;
    logic [31:0] r_last, r_time;
    logic [20:0] r_filt;
    logic [23:0] r_duty;
    logic [22:0] r_prev;
    logic [12:0] r_target;
    logic        r_stalled;

    logic [IW-1:0] r_med_idx;
    logic [31:0]   r_median;

    logic [DIV_W-1:0]     r_div_q, r_div_r, r_div_d;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [20:0]          r_ema_q;

    logic signed [40:0] r_prod_p, r_prod_i;
    logic signed [33:0] r_delta;

    logic        r_out_valid;
    logic [7:0]  r_out_duty;
    logic [12:0] r_out_speed;
    logic        r_out_stall;

    logic [31:0] elapsed, age, cand;
    logic [15:0] tgt_lo;
    logic [CW-1:0] cnt_lt, cnt_le;
    logic          med_hit;
    logic [DIV_W:0]   rem_sh;
    logic             rem_ge;
    logic [DIV_W-1:0] speed_den;
    logic [23:0]      ema_num;
    logic [47:0]      ema_prod;
    logic signed [22:0] err;
    logic signed [23:0] err_diff;
    logic signed [16:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [40:0] prod;
    logic signed [41:0] pi_sum;
    logic signed [34:0] acc, acc_lo, acc_hi;
    logic [21:0] speed_rnd;

    assign elapsed = i_time_us - r_last;
    assign age     = r_time - r_last;
    assign tgt_lo  = (i_target_rpm < {3'b000, r_tgt_floor}) ? {3'b000, r_tgt_floor}
                                                            : i_target_rpm;

    assign cand = r_ring[r_med_idx];
    always_comb begin
        cnt_lt = '0;
        cnt_le = '0;
        for (int j = 0; j < RING_DEPTH; j++) begin
            if (r_ring[j] < cand)  cnt_lt = cnt_lt + CW'(1);
            if (r_ring[j] <= cand) cnt_le = cnt_le + CW'(1);
        end
    end
    assign med_hit = (cnt_lt <= CW'(MED_K)) && (cnt_le > CW'(MED_K));

    assign rem_sh    = {r_div_r, r_div_q[DIV_W-1]};
    assign rem_ge    = rem_sh >= {1'b0, r_div_d};
    assign speed_den = DIV_W'(r_median) * DIV_W'(PULSES_PER_REV);
    assign ema_num   = {3'b000, r_div_q[20:0]} + {1'b0, r_filt, 2'b00} + 24'd2;
    assign ema_prod  = ema_num * EMA_RECIP;

    assign err      = $signed({2'b00, r_target, 8'h00}) - $signed({2'b00, r_filt});
    assign err_diff = $signed({err[22], err}) - $signed({r_prev[22], r_prev});
    assign mul_a    = i_cmd.mul_p ? $signed({1'b0, r_gain_p}) : $signed({1'b0, r_gain_i});
    assign mul_b    = i_cmd.mul_p ? err_diff : $signed({err[22], err});
    assign prod     = mul_a * mul_b;
    assign pi_sum   = $signed({r_prod_p[40], r_prod_p}) + $signed({r_prod_i[40], r_prod_i})
                    + 42'sd128;
    assign acc      = $signed({11'b0, r_duty}) + $signed({r_delta[33], r_delta});
    assign acc_lo   = $signed({11'b0, r_duty_floor, 16'h0000});
    assign acc_hi   = $signed({11'b0, r_duty_ceiling, 16'h0000});
    assign speed_rnd = {1'b0, r_filt} + 22'd128;

    assign o_sts.age_over = age > {8'h00, r_stall_to};
    assign o_sts.med_last = (r_med_idx == IW'(RING_DEPTH - 1));
    assign o_sts.med_zero = (r_median == '0);
    assign o_sts.div_done = (r_div_cnt == DIV_CNT_W'(DIV_W - 1));
    assign o_sts.raw_ok   = (r_div_q < SPEED_LIMIT);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_duty_level = r_out_duty;
    assign o_speed_rpm  = r_out_speed;
    assign o_stalled    = r_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p       <= RST_GAIN_P;
            r_gain_i       <= RST_GAIN_I;
            r_duty_floor   <= RST_DUTY_FLOOR;
            r_duty_ceiling <= RST_DUTY_CEILING;
            r_tgt_floor    <= RST_TGT_FLOOR;
            r_tgt_ceiling  <= RST_TGT_CEILING;
            r_debounce     <= RST_DEBOUNCE;
            r_stall_to     <= RST_STALL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GAIN_P:       r_gain_p       <= i_cfg_data[15:0];
                REG_GAIN_I:       r_gain_i       <= i_cfg_data[15:0];
                REG_DUTY_FLOOR:   r_duty_floor   <= i_cfg_data[7:0];
                REG_DUTY_CEILING: r_duty_ceiling <= i_cfg_data[7:0];
                REG_TGT_FLOOR:    r_tgt_floor    <= i_cfg_data[12:0];
                REG_TGT_CEILING:  r_tgt_ceiling  <= i_cfg_data[12:0];
                REG_DEBOUNCE:     r_debounce     <= i_cfg_data[15:0];
                REG_STALL:        r_stall_to     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RING_DEPTH; k++) r_ring[k] <= '0;
            r_pos       <= '0;
            r_last      <= '0;
            r_filt      <= '0;
            r_duty      <= RST_DUTY_ACC;
            r_prev      <= '0;
            r_target    <= RST_TARGET;
            r_stalled   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && i_command == CMD_PULSE && elapsed > {16'h0000, r_debounce}) begin
                r_ring[r_pos] <= elapsed;
                r_pos  <= (r_pos == IW'(RING_DEPTH - 1)) ? '0 : r_pos + IW'(1);
                r_last <= i_time_us;
            end
            if (i_cmd.accept && i_command == CMD_TARGET) begin
                r_target <= (tgt_lo > {3'b000, r_tgt_ceiling}) ? r_tgt_ceiling : tgt_lo[12:0];
            end
            if (i_cmd.stall_set) begin
                r_filt    <= '0;
                r_stalled <= 1'b1;
            end
            if (i_cmd.med_clear) r_stalled <= 1'b0;
            if (i_cmd.ema_write) r_filt <= r_ema_q;
            if (i_cmd.pi_acc) begin
                if (acc < acc_lo) begin
                    r_duty <= acc_lo[23:0];
                end else if (acc > acc_hi) begin
                    r_duty <= acc_hi[23:0];
                end else begin
                    r_duty <= acc[23:0];
                end
                r_prev <= err;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_time <= i_time_us;
        if (i_cmd.med_clear) r_med_idx <= '0;
        if (i_cmd.med_step) begin
            if (med_hit) r_median <= cand;
            r_med_idx <= r_med_idx + IW'(1);
        end
        if (i_cmd.div_speed) begin
            r_div_q   <= SPEED_NUM;
            r_div_d   <= speed_den;
            r_div_r   <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_r   <= rem_ge ? DIV_W'(rem_sh - {1'b0, r_div_d}) : rem_sh[DIV_W-1:0];
            r_div_q   <= {r_div_q[DIV_W-2:0], rem_ge};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.div_ema) r_ema_q <= ema_prod[46:26];
        if (i_cmd.mul_p) r_prod_p <= prod;
        if (i_cmd.mul_i) r_prod_i <= prod;
        if (i_cmd.pi_sum) r_delta <= pi_sum[41:8];
        if (i_cmd.out_load) begin
            r_out_duty  <= r_duty[23:16];
            r_out_speed <= speed_rnd[20:8];
            r_out_stall <= r_stalled;
        end
    end

endmodule

>>> sv/fan_speed_pi_controller_unit.sv
// ----------------------------------------------------------------------------
// Fan speed PI controller
// Median tachometer speed estimate, EMA filter and velocity-form PI duty loop.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tuser carries the command (tach edge, control tick,
// set target); s_axis_tdata carries the timestamp and the requested speed.
// Edge and target beats give no result. A tick beat gives
// one result beat on the output stream: duty and rounded speed in tdata,
// the stall flag in tuser.
// A tick runs the median scan, the serial speed divider, a reciprocal
// multiply for the filter, then the PI steps (P product, I product, sum,
// accumulate) and loads the result. A stall skips straight to the PI steps;
// an empty ring or an out-of-range reading skips the rest of the speed path.
// The output register holds one result; the input takes new beats while it
// waits. If the receiver stalls and a second tick finishes, the block holds
// and drops s_axis_tready until the register frees.
// Reset restores config and loop state registers and clears the period ring.
// The config port is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module fan_speed_pi_controller_unit #(
    parameter int RING_DEPTH     = 5,
    parameter int PULSES_PER_REV = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // time_us[31:0], target_rpm[47:32]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // duty_level[7:0], speed_rpm[20:8], zero[23:21]
    output logic        m_axis_tuser,   // stalled[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import fspc_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic [7:0]  duty_level;
    logic [12:0] speed_rpm;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {3'b000, speed_rpm, duty_level};

    fspc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_command (s_axis_tuser),
        .i_sts     (sts),
        .o_ready   (s_axis_tready),
        .o_cmd     (cmd)
    );

    fspc_dp #(
        .RING_DEPTH     (RING_DEPTH),
        .PULSES_PER_REV (PULSES_PER_REV)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_command    (s_axis_tuser),
        .i_time_us    (s_axis_tdata[31:0]),
        .i_target_rpm (s_axis_tdata[47:32]),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_duty_level (duty_level),
        .o_speed_rpm  (speed_rpm),
        .o_stalled    (m_axis_tuser)
    );

endmodule

>>> sv/fspc_checker.sv
// ----------------------------------------------------------------------------
// Fan speed PI controller port checker
// Port-level properties of the controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "fan_speed_pi_controller_unit_assert.svh"

module fspc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        o_cfg_ready
);
    import fspc_pkg::*;

    `FSPC_ASSERT_NXT(a_tick_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_TICK, !s_axis_tready)
    `FSPC_ASSERT_NXT(a_quick_cmd, s_axis_tvalid && s_axis_tready && s_axis_tuser != CMD_TICK, s_axis_tready)
    `FSPC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `FSPC_ASSERT_IMP(a_out_pad, m_axis_tvalid, m_axis_tdata[23:21] == 3'b000)
    `FSPC_ASSERT_IMP(a_cfg_ready, 1'b1, o_cfg_ready)

endmodule

bind fan_speed_pi_controller_unit fspc_checker u_fspc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .o_cfg_ready   (o_cfg_ready)
);

>>> verif/fan_speed_pi_controller_unit_test.sv
// ----------------------------------------------------------------------------
// Fan speed PI controller testbench
// Drives tach edges, control ticks and target requests through the input
// stream with random gaps, writes the config registers between phases, and
// checks every result beat against a fixed-point model of the speed filter
// and PI duty loop kept in a small scoreboard.
// ----------------------------------------------------------------------------
module fan_speed_pi_controller_unit_test;
    import fspc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 5;
    localparam int PPR   = 2;

    class fan_scoreboard;
        bit [15:0] kp, ki, dbnc;
        bit [7:0]  dmin, dmax;
        bit [12:0] tmin, tmax, target;
        bit [23:0] stall_to, duty_acc;
        bit [31:0] periods[DEPTH];
        int        wr_pos;
        bit [31:0] last_pulse;
        bit [20:0] speed_q8;
        int        prev_err;
        bit [24:0] pending[$];
        int        errors;

        function void restore();
            kp = RST_GAIN_P; ki = RST_GAIN_I; dmin = RST_DUTY_FLOOR;
            dmax = RST_DUTY_CEILING; tmin = RST_TGT_FLOOR; tmax = RST_TGT_CEILING;
            dbnc = RST_DEBOUNCE; stall_to = RST_STALL;
            foreach (periods[i]) periods[i] = 0;
            wr_pos = 0; last_pulse = 0; speed_q8 = 0;
            duty_acc = RST_DUTY_ACC; prev_err = 0; target = RST_TARGET;
            errors = 0;
        endfunction

        function void write_reg(bit [3:0] idx, bit [23:0] val);
            case (idx)
                REG_GAIN_P:       kp = val[15:0];
                REG_GAIN_I:       ki = val[15:0];
                REG_DUTY_FLOOR:   dmin = val[7:0];
                REG_DUTY_CEILING: dmax = val[7:0];
                REG_TGT_FLOOR:    tmin = val[12:0];
                REG_TGT_CEILING:  tmax = val[12:0];
                REG_DEBOUNCE:     dbnc = val[15:0];
                REG_STALL:        stall_to = val;
                default: ;
            endcase
        endfunction

        function bit [31:0] median();
            bit [31:0] s[DEPTH];
            bit [31:0] v;
            s = periods;
            for (int i = 1; i < DEPTH; i++) begin
                for (int j = i; j > 0; j--) begin
                    if (s[j-1] > s[j]) begin
                        v = s[j]; s[j] = s[j-1]; s[j-1] = v;
                    end
                end
            end
            return s[DEPTH/2];
        endfunction

        function void note_input(bit [1:0] cmd, bit [31:0] now, bit [15:0] req);
            bit [31:0] el, med;
            longint raw, d, acc, lo, hi;
            int e;
            bit stl;
            int unsigned t;
            el = now - last_pulse;
            if (cmd == CMD_PULSE) begin
                if (el > dbnc) begin
                    periods[wr_pos] = el;
                    wr_pos = (wr_pos + 1 >= DEPTH) ? 0 : wr_pos + 1;
                    last_pulse = now;
                end
            end else if (cmd == CMD_TARGET) begin
                t = req;
                if (t < tmin) t = tmin;
                if (t > tmax) t = tmax;
                target = t[12:0];
            end else if (cmd == CMD_TICK) begin
                stl = 0;
                if (el > stall_to) begin
                    speed_q8 = 0;
                    stl = 1;
                end else begin
                    med = median();
                    if (med > 0) begin
                        raw = 64'd15360000000 / (longint'(med) * PPR);
                        if (raw < 6000 * 256)
                            speed_q8 = 21'((raw + 4 * longint'(speed_q8) + 2) / 5);
                    end
                end
                e = (int'(target) << 8) - int'(speed_q8);
                d = longint'(kp) * (longint'(e) - prev_err) + longint'(ki) * e;
                d = (d + 128) >>> 8;
                prev_err = e;
                acc = longint'(duty_acc) + d;
                lo = longint'(dmin) << 16;
                hi = longint'(dmax) << 16;
                if (acc < lo) acc = lo;
                else if (acc > hi) acc = hi;
                duty_acc = acc[23:0];
                pending.push_back({stl, 3'b000, 13'((speed_q8 + 128) >> 8), duty_acc[23:16]});
            end
        endfunction

        function void check_result(bit [23:0] data, bit user);
            bit [24:0] exp_v;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, actual data %h stalled %0d", $time, data, user);
                errors++;
                return;
            end
            exp_v = pending.pop_front();
            if (data[7:0] != exp_v[7:0]) begin
                $display("%0t: duty expected %0d actual %0d", $time, exp_v[7:0], data[7:0]);
                errors++;
            end
            if (data[20:8] != exp_v[20:8]) begin
                $display("%0t: speed_rpm expected %0d actual %0d", $time, exp_v[20:8], data[20:8]);
                errors++;
            end
            if (data[23:21] != 3'b000) begin
                $display("%0t: pad bits expected 0 actual %0d", $time, data[23:21]);
                errors++;
            end
            if (user != exp_v[24]) begin
                $display("%0t: stalled expected %0d actual %0d", $time, exp_v[24], user);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = 0;
    logic [1:0]  s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index = 0;
    logic [23:0] i_cfg_data = 0;

    fan_scoreboard sb;
    bit            no_idle;
    bit [31:0]     clock_us;

    fan_speed_pi_controller_unit #(.RING_DEPTH(DEPTH), .PULSES_PER_REV(PPR)) dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[47:32]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    initial begin
        int w;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            w = no_idle ? 0 : $urandom_range(0, 4);
            if (w > 0) begin
                m_axis_tready <= 0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_beat(bit [1:0] cmd, bit [31:0] now, bit [15:0] req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        i_cfg_valid <= 0;
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {req, now};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_cfg(bit [3:0] idx, bit [23:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic pulse_after(int unsigned dt);
        clock_us += dt;
        send_beat(CMD_PULSE, clock_us, 16'($urandom));
    endtask

    task automatic tick_after(int unsigned dt);
        clock_us += dt;
        send_beat(CMD_TICK, clock_us, 16'($urandom));
    endtask

    task automatic run_phase(int count, int unsigned base);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 55) pulse_after(base + $urandom_range(0, base / 8));
            else if (r < 80) tick_after($urandom_range(0, base));
            else if (r < 88) send_beat(CMD_TARGET, clock_us, 16'($urandom));
            else if (r < 91) send_beat(2'd3, $urandom, 16'($urandom));
            else if (r < 95) pulse_after($urandom_range(0, 4000));
            else if (r < 97) tick_after($urandom_range(400000, 2000000));
            else begin
                clock_us = $urandom;
                send_beat($urandom_range(0, 1), clock_us, 16'($urandom));
            end
        end
    endtask

    initial begin
        bit [23:0] v[8];
        int unsigned base;
        sb = new();
        sb.restore();
        no_idle = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: defaults, empty ring, stall, fast and slow fan, targets
        tick_after(100);
        send_beat(2'd3, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(CMD_TARGET, clock_us, 16'd0);
        send_beat(CMD_TARGET, clock_us, 16'hFFFF);
        tick_after(600000);
        for (int i = 0; i < 6; i++) pulse_after(10000);
        pulse_after(3000);
        pulse_after(1);
        tick_after(5000);
        send_beat(CMD_TARGET, clock_us, 16'd2500);
        tick_after(100);
        clock_us = 32'hFFFF_F000;
        send_beat(CMD_PULSE, clock_us, 16'd0);
        for (int i = 0; i < 4; i++) pulse_after(8000);
        tick_after(100);
        drain();

        write_cfg(REG_DEBOUNCE, 24'd0);
        write_cfg(REG_GAIN_P, 24'hFFFF);
        write_cfg(REG_GAIN_I, 24'hFFFF);
        write_cfg(4'd9, 24'hFFFFFF);
        for (int i = 0; i < 5; i++) pulse_after(1000);
        tick_after(10);
        pulse_after(1);
        tick_after(10);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            no_idle = (ph % 4 == 3);
            v[0] = (ph == 1) ? 0 : (ph == 2) ? 24'hFFFF : $urandom_range(0, 4000);
            v[1] = (ph == 1) ? 0 : (ph == 2) ? 24'hFFFF : $urandom_range(0, 1000);
            v[2] = (ph == 4) ? 200 : (ph == 5) ? 0 : $urandom_range(0, 40);
            v[3] = (ph == 4) ? 100 : (ph == 5) ? 255 : $urandom_range(180, 255);
            v[4] = (ph == 6) ? 24'h1FFF : (ph == 5) ? 0 : $urandom_range(0, 3000);
            v[5] = (ph == 6) ? 1000 : (ph == 5) ? 24'h1FFF : $urandom_range(3000, 8191);
            v[6] = (ph == 7) ? 24'hFFFF : (ph == 8) ? 0 : $urandom_range(0, 4000);
            v[7] = (ph == 7) ? 24'hFFFFFF : (ph == 8) ? 0 : $urandom_range(100000, 800000);
            for (int i = 0; i < 8; i++) write_cfg(i[3:0], $urandom_range(0, 1) ? v[i] : v[i]);
            if (ph == 0) write_cfg(4'd15, 24'h000001);
            base = (ph % 3 == 0) ? $urandom_range(1500, 4000) : $urandom_range(4000, 60000);
            if (ph == 7) base = 70000;
            run_phase(110, base);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
